/* rtl/bfnc_pkg.sv */
// Shared constants and types for the Bellman-Ford negative cycle block.
package bfnc_pkg;
    localparam int MAX_V   = 32;
    localparam int V_W     = $clog2(MAX_V);
    localparam int N_W     = $clog2(MAX_V + 1);
    localparam int MAX_E   = 256;
    localparam int E_AW    = $clog2(MAX_E);
    localparam int ET_W    = $clog2(MAX_E + 1);
    localparam int W_W     = 16;
    localparam int DIST_W  = 31;
    localparam int SUM_W   = DIST_W + 1;
    localparam int DIST_INF = 1000000000;
    localparam int PATH_D  = MAX_V + 1;
    localparam int PATH_AW = $clog2(PATH_D);
    localparam int EDGE_W  = 2 * V_W + W_W;

    localparam logic [0:0] REG_START = 1'b0;
    localparam logic [0:0] REG_COUNT = 1'b1;

    localparam logic KIND_DIST  = 1'b0;
    localparam logic KIND_CYCLE = 1'b1;

    typedef struct packed {
        logic [V_W-1:0]        src;
        logic [V_W-1:0]        dst;
        logic signed [W_W-1:0] weight;
    } edge_t;
endpackage

/* rtl/bfnc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bfnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/bellman_ford_negative_cycle_top.sv */
// Bellman-Ford shortest paths with negative cycle detection, top level.
// Loading: one edge beat per cycle while idle; the last_edge beat starts a run.
// Run: dist/pred table clear, then n rounds over the stored edges, each edge in order
//   (edge read, dist[src] read, dist[dst] read, write back on one RAM port).
// Results: a distance beat per vertex, or cycle beats after a pred walk and path build.
// Reset (rst_n, async, low): idle, no edges stored, start_vertex 0, vertex_count 32.
module bellman_ford_negative_cycle_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [0:0]                           cfg_index,
    input  logic [bfnc_pkg::N_W-1:0]             cfg_data,
    // edge input
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bfnc_pkg::V_W-1:0]             edge_src,
    input  logic [bfnc_pkg::V_W-1:0]             edge_dst,
    input  logic signed [bfnc_pkg::W_W-1:0]      edge_weight,
    input  logic                                 last_edge,
    // result output
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 kind,
    output logic [bfnc_pkg::V_W-1:0]             vertex,
    output logic signed [bfnc_pkg::DIST_W-1:0]   distance,
    output logic                                 reachable,
    output logic                                 negative_cycle,
    output logic                                 last
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_RD_EDGE, S_RD_A, S_RD_B, S_UPD,
        S_WALK_RD, S_WALK_WT, S_C_RD, S_C_WT,
        S_OC_RD, S_OC_P, S_OC_D, S_R_RD, S_R_D
    } state_t;

    state_t                             state_reg;
    logic [bfnc_pkg::V_W-1:0]           start_reg;
    logic [bfnc_pkg::N_W-1:0]           count_reg;
    logic [bfnc_pkg::N_W-1:0]           n_reg;
    logic [bfnc_pkg::ET_W-1:0]          total_reg;
    logic [bfnc_pkg::ET_W-1:0]          e_reg;
    logic [bfnc_pkg::N_W-1:0]           round_reg;
    logic [bfnc_pkg::V_W-1:0]           clr_reg;
    logic                               lrv_none_reg;
    logic [bfnc_pkg::V_W-1:0]           lrv_reg;
    bfnc_pkg::edge_t                    cur_reg;
    logic signed [bfnc_pkg::SUM_W-1:0]  da_reg;
    logic [bfnc_pkg::V_W-1:0]           y_reg;
    logic [bfnc_pkg::V_W-1:0]           anchor_reg;
    logic [bfnc_pkg::PATH_AW-1:0]       len_reg;
    logic [bfnc_pkg::PATH_AW-1:0]       idx_reg;
    logic [bfnc_pkg::V_W-1:0]           v_reg;
    logic                               out_valid_reg;
    logic                               kind_reg;
    logic [bfnc_pkg::V_W-1:0]           vertex_reg;
    logic signed [bfnc_pkg::DIST_W-1:0] distance_reg;
    logic                               reach_reg;
    logic                               neg_reg;
    logic                               last_reg;

    // memories
    logic                               e_we, e_re;
    logic [bfnc_pkg::E_AW-1:0]          e_waddr, e_raddr;
    bfnc_pkg::edge_t                    e_wdata, e_rdata;
    logic                               d_we, d_re;
    logic [bfnc_pkg::V_W-1:0]           d_waddr, d_raddr;
    logic signed [bfnc_pkg::DIST_W-1:0] d_wdata, d_rdata;
    logic                               p_we, p_re;
    logic [bfnc_pkg::V_W-1:0]           p_waddr, p_raddr, p_wdata, p_rdata;
    logic                               q_we, q_re;
    logic [bfnc_pkg::PATH_AW-1:0]       q_waddr, q_raddr;
    logic [bfnc_pkg::V_W-1:0]           q_wdata, q_rdata;

    logic                               in_acc, out_free, store_ok, skip_a;
    logic                               emit;
    logic signed [bfnc_pkg::SUM_W-1:0]  db_ext, cand, clamped;
    logic                               better;
    logic [bfnc_pkg::N_W-1:0]           n_eff;
    logic                               start_in;

    bfnc_ram #(.WIDTH(bfnc_pkg::EDGE_W), .DEPTH(bfnc_pkg::MAX_E)) u_edges (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
    );
    bfnc_ram #(.WIDTH(bfnc_pkg::DIST_W), .DEPTH(bfnc_pkg::MAX_V)) u_dist (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
    );
    bfnc_ram #(.WIDTH(bfnc_pkg::V_W), .DEPTH(bfnc_pkg::MAX_V)) u_pred (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
    );
    bfnc_ram #(.WIDTH(bfnc_pkg::V_W), .DEPTH(bfnc_pkg::PATH_D)) u_path (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign store_ok  = (total_reg < bfnc_pkg::ET_W'(bfnc_pkg::MAX_E));
    // a new result beat is loaded this cycle
    assign emit      = ((state_reg == S_OC_D) || (state_reg == S_R_D)) && out_free;

    // vertex_count 0 acts as 1, above MAX_V as MAX_V
    always_comb
    begin
        if (count_reg == '0)
            n_eff = bfnc_pkg::N_W'(1);
        else if (count_reg > bfnc_pkg::N_W'(bfnc_pkg::MAX_V))
            n_eff = bfnc_pkg::N_W'(bfnc_pkg::MAX_V);
        else
            n_eff = count_reg;
    end

    assign start_in = ({1'b0, start_reg} < n_reg);
    assign skip_a   = ({1'b0, e_rdata.src} >= n_reg) || ({1'b0, e_rdata.dst} >= n_reg);

    // relaxation arithmetic
    assign db_ext  = bfnc_pkg::SUM_W'(d_rdata);
    assign cand    = da_reg + bfnc_pkg::SUM_W'(cur_reg.weight);
    assign better  = (cand < db_ext);
    assign clamped = (cand < -bfnc_pkg::SUM_W'(bfnc_pkg::DIST_INF))
                   ? -bfnc_pkg::SUM_W'(bfnc_pkg::DIST_INF) : cand;

    always_comb
    begin
        e_we    = (state_reg == S_IDLE) && in_acc && store_ok;
        e_waddr = total_reg[bfnc_pkg::E_AW-1:0];
        e_wdata = '{src: edge_src, dst: edge_dst, weight: edge_weight};
        e_re    = (state_reg == S_RD_EDGE);
        e_raddr = e_reg[bfnc_pkg::E_AW-1:0];

        d_we    = 1'b0;
        d_waddr = clr_reg;
        d_wdata = bfnc_pkg::DIST_W'(bfnc_pkg::DIST_INF);
        p_we    = 1'b0;
        p_waddr = clr_reg;
        p_wdata = '0;
        d_re    = 1'b0;
        d_raddr = e_rdata.src;
        p_re    = 1'b0;
        p_raddr = y_reg;
        q_we    = 1'b0;
        q_waddr = len_reg;
        q_wdata = y_reg;
        q_re    = (state_reg == S_OC_RD);
        q_raddr = idx_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                d_we = 1'b1;
                p_we = 1'b1;
                if (start_in && clr_reg == start_reg)
                    d_wdata = '0;
            end
            S_RD_A:
            begin
                d_re = 1'b1;
            end
            S_RD_B:
            begin
                d_re    = 1'b1;
                d_raddr = cur_reg.dst;
            end
            S_UPD:
            begin
                d_we    = better;
                d_waddr = cur_reg.dst;
                d_wdata = bfnc_pkg::DIST_W'(clamped);
                p_we    = better;
                p_waddr = cur_reg.dst;
                p_wdata = cur_reg.src;
            end
            S_WALK_RD, S_C_RD:
            begin
                p_re = 1'b1;
                q_we = (state_reg == S_C_RD);
            end
            S_C_WT:
            begin
                // end of walk: close the path with the anchor
                q_we    = !((p_rdata != anchor_reg) && ({1'b0, len_reg} < {1'b0, n_reg}));
                q_wdata = anchor_reg;
            end
            S_OC_P:
            begin
                d_re    = 1'b1;
                d_raddr = q_rdata;
            end
            S_R_RD:
            begin
                d_re    = 1'b1;
                d_raddr = v_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= '0;
            count_reg     <= bfnc_pkg::N_W'(bfnc_pkg::MAX_V);
            n_reg         <= bfnc_pkg::N_W'(bfnc_pkg::MAX_V);
            total_reg     <= '0;
            e_reg         <= '0;
            round_reg     <= '0;
            clr_reg       <= '0;
            lrv_none_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bfnc_pkg::REG_START: start_reg <= cfg_data[bfnc_pkg::V_W-1:0];
                    bfnc_pkg::REG_COUNT: count_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid_reg && !out_stall && !emit)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (store_ok)
                            total_reg <= total_reg + 1'b1;
                        if (last_edge)
                        begin
                            n_reg     <= n_eff;
                            clr_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == bfnc_pkg::V_W'(bfnc_pkg::MAX_V - 1))
                    begin
                        round_reg    <= '0;
                        e_reg        <= '0;
                        lrv_none_reg <= 1'b1;
                        state_reg    <= S_RD_EDGE;
                    end
                end
                S_RD_EDGE:
                begin
                    if (e_reg == total_reg)
                    begin
                        if (round_reg == n_reg - 1'b1)
                        begin
                            total_reg <= '0;
                            round_reg <= '0;
                            y_reg     <= lrv_reg;
                            v_reg     <= '0;
                            state_reg <= lrv_none_reg ? S_R_RD : S_WALK_RD;
                        end
                        else
                        begin
                            round_reg    <= round_reg + 1'b1;
                            e_reg        <= '0;
                            lrv_none_reg <= 1'b1;
                        end
                    end
                    else
                        state_reg <= S_RD_A;
                end
                S_RD_A:
                begin
                    cur_reg <= e_rdata;
                    if (skip_a)
                    begin
                        e_reg     <= e_reg + 1'b1;
                        state_reg <= S_RD_EDGE;
                    end
                    else
                        state_reg <= S_RD_B;
                end
                S_RD_B:
                begin
                    da_reg <= bfnc_pkg::SUM_W'(d_rdata);
                    if (d_rdata >= bfnc_pkg::DIST_W'(bfnc_pkg::DIST_INF))
                    begin
                        e_reg     <= e_reg + 1'b1;
                        state_reg <= S_RD_EDGE;
                    end
                    else
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (better)
                    begin
                        lrv_reg      <= cur_reg.dst;
                        lrv_none_reg <= 1'b0;
                    end
                    e_reg     <= e_reg + 1'b1;
                    state_reg <= S_RD_EDGE;
                end
                S_WALK_RD:
                begin
                    state_reg <= S_WALK_WT;
                end
                S_WALK_WT:
                begin
                    y_reg     <= p_rdata;
                    round_reg <= round_reg + 1'b1;
                    if (round_reg + 1'b1 == n_reg)
                    begin
                        anchor_reg <= p_rdata;
                        len_reg    <= '0;
                        state_reg  <= S_C_RD;
                    end
                    else
                        state_reg <= S_WALK_RD;
                end
                S_C_RD:
                begin
                    len_reg   <= len_reg + 1'b1;
                    state_reg <= S_C_WT;
                end
                S_C_WT:
                begin
                    y_reg <= p_rdata;
                    if ((p_rdata != anchor_reg) && ({1'b0, len_reg} < {1'b0, n_reg}))
                        state_reg <= S_C_RD;
                    else
                    begin
                        idx_reg   <= len_reg;
                        state_reg <= S_OC_RD;
                    end
                end
                S_OC_RD:
                begin
                    state_reg <= S_OC_P;
                end
                S_OC_P:
                begin
                    state_reg <= S_OC_D;
                end
                S_OC_D:
                begin
                    // path read data holds until the next path read
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= bfnc_pkg::KIND_CYCLE;
                        vertex_reg    <= q_rdata;
                        distance_reg  <= d_rdata;
                        reach_reg     <= (d_rdata < bfnc_pkg::DIST_W'(bfnc_pkg::DIST_INF));
                        neg_reg       <= 1'b1;
                        last_reg      <= (idx_reg == '0);
                        idx_reg       <= idx_reg - 1'b1;
                        state_reg     <= (idx_reg == '0) ? S_IDLE : S_OC_RD;
                    end
                end
                S_R_RD:
                begin
                    state_reg <= S_R_D;
                end
                S_R_D:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= bfnc_pkg::KIND_DIST;
                        vertex_reg    <= v_reg;
                        distance_reg  <= d_rdata;
                        reach_reg     <= (d_rdata < bfnc_pkg::DIST_W'(bfnc_pkg::DIST_INF));
                        neg_reg       <= 1'b0;
                        last_reg      <= ({1'b0, v_reg} == n_reg - 1'b1);
                        v_reg         <= v_reg + 1'b1;
                        state_reg     <= ({1'b0, v_reg} == n_reg - 1'b1) ? S_IDLE : S_R_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign vertex         = vertex_reg;
    assign distance       = distance_reg;
    assign reachable      = reach_reg;
    assign negative_cycle = neg_reg;
    assign last           = last_reg;
endmodule

/* rtl/bfnc_checker.sv */
// Port-level checks for the Bellman-Ford negative cycle block, with bind.
module bfnc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 last_edge,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic                                 kind,
    input logic [bfnc_pkg::V_W-1:0]             vertex,
    input logic signed [bfnc_pkg::DIST_W-1:0]   distance,
    input logic                                 reachable,
    input logic                                 negative_cycle
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex) && $stable(distance))
        else $error("stalled result beat changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (negative_cycle == (kind == bfnc_pkg::KIND_CYCLE)))
        else $error("negative_cycle flag disagrees with kind");

    a_reach: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reachable == (distance < bfnc_pkg::DIST_W'(bfnc_pkg::DIST_INF))))
        else $error("reachable disagrees with distance");

    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_edge |=> in_stall)
        else $error("input not held off after last edge");
endmodule

bind bellman_ford_negative_cycle_top bfnc_checker u_bfnc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .last_edge(last_edge), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .vertex(vertex), .distance(distance), .reachable(reachable),
    .negative_cycle(negative_cycle)
);

/* tb/tb.sv */
// Self-checking testbench for the Bellman-Ford negative cycle block.
`timescale 1ns / 100ps

module tb;
    // Clock and reset
    logic clk;
    logic rst_n;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Block ports
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [0:0]                         cfg_index;
    logic [bfnc_pkg::N_W-1:0]           cfg_data;
    logic                               in_valid;
    logic                               in_stall;
    logic [bfnc_pkg::V_W-1:0]           edge_src;
    logic [bfnc_pkg::V_W-1:0]           edge_dst;
    logic signed [bfnc_pkg::W_W-1:0]    edge_weight;
    logic                               last_edge;
    logic                               out_valid;
    logic                               out_stall;
    logic                               kind;
    logic [bfnc_pkg::V_W-1:0]           vertex;
    logic signed [bfnc_pkg::DIST_W-1:0] distance;
    logic                               reachable;
    logic                               negative_cycle;
    logic                               last;

    bellman_ford_negative_cycle_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .edge_src       (edge_src),
        .edge_dst       (edge_dst),
        .edge_weight    (edge_weight),
        .last_edge      (last_edge),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .vertex         (vertex),
        .distance       (distance),
        .reachable      (reachable),
        .negative_cycle (negative_cycle),
        .last           (last)
    );

    // One edge beat and one result beat
    typedef struct packed {
        logic [bfnc_pkg::V_W-1:0]        src;
        logic [bfnc_pkg::V_W-1:0]        dst;
        logic signed [bfnc_pkg::W_W-1:0] weight;
        logic                            fin;
    } edge_beat_t;

    typedef struct packed {
        logic                               kind;
        logic [bfnc_pkg::V_W-1:0]           vertex;
        logic signed [bfnc_pkg::DIST_W-1:0] distance;
        logic                               reachable;
        logic                               negcyc;
        logic                               last;
    } path_result_t;

    // Predictor state: graph under construction, tables, and registers
    edge_beat_t               graph_edges[bfnc_pkg::MAX_E];
    int                       graph_size = 0;
    longint                   dist_tab[bfnc_pkg::MAX_V];
    logic [bfnc_pkg::V_W-1:0] pred_tab[bfnc_pkg::MAX_V];
    int unsigned              src_vertex_reg;
    int unsigned              vcount_reg;

    edge_beat_t   edge_queue[$];
    path_result_t expected_results[$];

    int  mismatches = 0;
    int  beats_sent = 0;
    int  results_seen = 0;
    int  cycle_runs = 0;
    int  dist_runs = 0;

    // Idling control: percent chance per cycle
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_recv;
    bit          hold_send;
    event        hold_go;

    // Stall as seen at the rising edge, so acceptance is decided at one instant
    logic       in_stall_q;
    edge_beat_t cur_beat;
    always @(posedge clk) in_stall_q <= in_stall;

    function automatic path_result_t make_result(logic k, int unsigned v, longint d,
                                                 logic l);
        path_result_t r;
        r.kind      = k;
        r.vertex    = v[bfnc_pkg::V_W-1:0];
        r.distance  = d[bfnc_pkg::DIST_W-1:0];
        r.reachable = (d < bfnc_pkg::DIST_INF);
        r.negcyc    = k;
        r.last      = l;
        return r;
    endfunction

    // Store one edge and, on the last edge, run the relaxation and queue results
    task automatic predict_shortest_paths(edge_beat_t b);
        int unsigned n;
        int          relaxed;
        int unsigned y;
        int unsigned anchor;
        int unsigned path[$];
        longint      cand;
        edge_beat_t  e;
        if (graph_size < bfnc_pkg::MAX_E)
        begin
            graph_edges[graph_size] = b;
            graph_size++;
        end
        if (!b.fin)
            return;
        n = vcount_reg;
        if (n < 1) n = 1;
        if (n > bfnc_pkg::MAX_V) n = bfnc_pkg::MAX_V;
        for (int i = 0; i < bfnc_pkg::MAX_V; i++)
        begin
            dist_tab[i] = bfnc_pkg::DIST_INF;
            pred_tab[i] = '0;
        end
        if (src_vertex_reg < n)
            dist_tab[src_vertex_reg] = 0;
        relaxed = -1;
        for (int r = 0; r < n; r++)
        begin
            relaxed = -1;
            for (int k = 0; k < graph_size; k++)
            begin
                e = graph_edges[k];
                if (e.src >= n || e.dst >= n) continue;
                if (dist_tab[e.src] >= bfnc_pkg::DIST_INF) continue;
                cand = dist_tab[e.src] + longint'(e.weight);
                if (cand < dist_tab[e.dst])
                begin
                    dist_tab[e.dst] = (cand < -longint'(bfnc_pkg::DIST_INF)) ?
                                      -longint'(bfnc_pkg::DIST_INF) : cand;
                    pred_tab[e.dst] = e.src;
                    relaxed = e.dst;
                end
            end
        end
        graph_size = 0;
        if (relaxed >= 0)
        begin
            cycle_runs++;
            y = relaxed;
            for (int i = 0; i < n; i++) y = pred_tab[y];
            anchor = y;
            do
            begin
                path = {path, y};
                y = pred_tab[y];
            end while (y != anchor && path.size() < n);
            path = {path, anchor};
            for (int k = path.size() - 1; k >= 0; k--)
                expected_results = {expected_results,
                                    make_result(bfnc_pkg::KIND_CYCLE, path[k],
                                                dist_tab[path[k]], k == 0)};
        end
        else
        begin
            dist_runs++;
            for (int v = 0; v < n; v++)
                expected_results = {expected_results,
                                    make_result(bfnc_pkg::KIND_DIST, v, dist_tab[v],
                                                v == n - 1)};
        end
    endtask

    // Driver: pops edge beats at the falling edge, holds them while stalled
    always @(negedge clk)
    begin
        bit took;
        bit busy;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            edge_src    <= '0;
            edge_dst    <= '0;
            edge_weight <= '0;
            last_edge   <= 1'b0;
            out_stall   <= 1'b0;
        end
        else
        begin
            took = in_valid && !in_stall_q;
            busy = in_valid && !took;
            if (took)
            begin
                predict_shortest_paths(cur_beat);
                beats_sent++;
            end
            if (!busy && !hold_send && edge_queue.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                cur_beat    <= edge_queue[0];
                edge_src    <= edge_queue[0].src;
                edge_dst    <= edge_queue[0].dst;
                edge_weight <= edge_queue[0].weight;
                last_edge   <= edge_queue[0].fin;
                in_valid    <= 1'b1;
                void'(edge_queue.pop_front());
            end
            else if (took)
                in_valid <= 1'b0;
            out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        path_result_t got;
        path_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind, vertex, distance, reachable, negative_cycle, last};
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Receiver hold-off counted in its own process
    always
    begin
        @(hold_go);
        @(negedge clk);
        hold_recv <= 1'b1;
        repeat (1500) @(negedge clk);
        hold_recv <= 1'b0;
    end

    task automatic write_reg(logic [0:0] idx, int unsigned val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val[bfnc_pkg::N_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == bfnc_pkg::REG_START) src_vertex_reg = val & 5'h1f;
        else                            vcount_reg     = val & 6'h3f;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until everything queued is sent and answered, then drain
    task automatic wait_idle();
        while (edge_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic edge_beat_t mk_edge(int s, int d, int w, bit f);
        edge_beat_t b;
        b.src = s[bfnc_pkg::V_W-1:0];
        b.dst = d[bfnc_pkg::V_W-1:0];
        b.weight = w[bfnc_pkg::W_W-1:0];
        b.fin = f;
        return b;
    endfunction

    task automatic queue_edge(int s, int d, int w, bit f);
        edge_queue = {edge_queue, mk_edge(s, d, w, f)};
    endtask

    // Random graph: edges mostly over n vertices, some with endpoints anywhere in 0..31
    task automatic add_random_graph(int n, int edges, bit allow_cycle);
        int s;
        int d;
        int w;
        for (int i = 0; i < edges; i++)
        begin
            s = $urandom_range(n - 1);
            d = $urandom_range(n - 1);
            case ($urandom_range(9))
                0: w = -32768;
                1: w = 32767;
                2, 3: w = allow_cycle ? -$urandom_range(200) : $urandom_range(200);
                4: w = $urandom & 16'hffff;
                5: begin s = $urandom_range(31); d = $urandom_range(31); w = $urandom; end
                default: w = allow_cycle ? $urandom_range(100) - 40 : $urandom_range(1000);
            endcase
            queue_edge(s, d, w, i == edges - 1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        hold_send = 1'b0;
        src_vertex_reg = 0; vcount_reg = 32;
        send_idle_pct = 21; recv_idle_pct = 48;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset config and extremes of weight on a small graph
        queue_edge(0, 1, 32767, 0);
        queue_edge(1, 31, -32768, 0);
        queue_edge(31, 0, 5, 1);
        wait_idle();

        // Small graph with a negative cycle 1->2->3->1
        write_reg(bfnc_pkg::REG_COUNT, 4);
        write_reg(bfnc_pkg::REG_START, 0);
        queue_edge(0, 1, 1, 0);
        queue_edge(1, 2, -3, 0);
        queue_edge(2, 3, 1, 0);
        queue_edge(3, 1, 1, 1);
        wait_idle();

        // Out-of-range endpoint skipped, start out of range, count 0 and above max
        write_reg(bfnc_pkg::REG_START, 31);
        queue_edge(0, 31, 2, 0);
        queue_edge(2, 1, -7, 1);
        wait_idle();
        write_reg(bfnc_pkg::REG_COUNT, 0);
        write_reg(bfnc_pkg::REG_START, 0);
        queue_edge(0, 0, -1, 1);
        wait_idle();
        write_reg(bfnc_pkg::REG_COUNT, 63);
        queue_edge(0, 5, -30000, 0);
        queue_edge(5, 6, -30000, 1);
        wait_idle();

        // Negative cycle on 2 vertices with the most negative weights
        write_reg(bfnc_pkg::REG_COUNT, 2);
        queue_edge(0, 1, -32768, 0);
        queue_edge(1, 0, -32768, 1);
        wait_idle();

        // Random phases: three idling mixes, various settings
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 48 : 0;
            recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 21 : 0;
            for (int g = 0; g < 6; g++)
            begin
                int n;
                n = (g == 5) ? 32 : $urandom_range(2, 10);
                write_reg(bfnc_pkg::REG_COUNT, (g == 4) ? 1 : n);
                write_reg(bfnc_pkg::REG_START, (g == 3) ? 31 : $urandom_range(n - 1));
                if (ph == 0 && g == 2)
                    -> hold_go; // long receiver hold while edges keep coming
                add_random_graph(n, $urandom_range(3, 9), $urandom_range(1));
                add_random_graph(n, 3, 1'b0);
                wait_idle(); // sender pauses until every result has come
            end
        end

        $display("Sent %0d edge beats, checked %0d results (%0d cycle runs, %0d distance runs)",
                 beats_sent, results_seen, cycle_runs, dist_runs);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end
endmodule
